### rtl/ljf_pkg.sv
// Shared types, constants and codes for the Lennard-Jones pair force pipeline.
// No dependencies; every other file imports this package.
package ljf_pkg;

    localparam int EXP_W     = 12;
    localparam int COEF_W    = 48;
    localparam int FORCE_W   = 48;
    localparam int NUM_COEF  = 6;
    localparam int D_W       = 34;
    localparam int U_W       = 33;
    localparam int SQ_W      = 2 * U_W;
    localparam int R_W       = SQ_W + 1;
    localparam int NORM_W    = 72;
    localparam int PROD_W    = U_W + 32;

    // Reciprocal divider layout: three quotient bits per stage
    localparam int RCP_STAGES = 11;
    localparam int RCP_STEPS  = 3;

    // Register stage numbers of the main pipeline
    localparam int ST_PAIR = 24;
    localparam int ST_FRC  = 32;
    localparam int ST_OUT  = 35;

    // Configuration register indexes
    localparam logic [2:0] REG_REP_00 = 3'd0;
    localparam logic [2:0] REG_ATT_00 = 3'd1;
    localparam logic [2:0] REG_REP_01 = 3'd2;
    localparam logic [2:0] REG_ATT_01 = 3'd3;
    localparam logic [2:0] REG_REP_11 = 3'd4;
    localparam logic [2:0] REG_ATT_11 = 3'd5;
    localparam logic [2:0] REG_COUNT  = 3'd6;

    // Type pair codes
    localparam logic [1:0] PAIR_00 = 2'd0;
    localparam logic [1:0] PAIR_01 = 2'd1;
    localparam logic [1:0] PAIR_11 = 2'd2;

    localparam logic [FORCE_W-1:0] FORCE_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_MIN = 48'h8000_0000_0000;

    typedef logic signed [EXP_W-1:0] t_exp;

    // Mantissa with bit 31 set, or zero, times 2^e
    typedef struct packed {
        logic [31:0] m;
        t_exp        e;
    } t_xnum;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_a_z;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] pos_b_z;
        logic signed [31:0] image_shift_x;
        logic signed [31:0] image_shift_y;
        logic signed [31:0] image_shift_z;
        logic               species_a;
        logic               species_b;
    } t_in;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      saturated;
    } t_out;

endpackage

### rtl/ljf_norm.sv
// Two-stage normalizer: bit length of a 72-bit word, then a left shift to a
// 32-bit mantissa with truncation. Depends on ljf_pkg.
module ljf_norm (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ljf_pkg::NORM_W-1:0]  i_v,
    input  ljf_pkg::t_exp               i_base,
    output ljf_pkg::t_xnum              o_z
);
    import ljf_pkg::*;

    logic [NORM_W-1:0] r_v;
    logic [6:0]        r_bl;
    t_exp              r_base;
    logic [6:0]        n_bl;
    logic [NORM_W-1:0] c_sh;
    t_xnum             r_z;

    // Find the bit length
    always_comb begin
        n_bl = '0;
        for (int i = 0; i < NORM_W; i++) begin
            if (i_v[i]) n_bl = 7'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= i_v;
            r_bl   <= n_bl;
            r_base <= i_base;
        end
    end

    // Shift the leading one to the top; a zero word stays zero
    assign c_sh = r_v << (7'(NORM_W) - r_bl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z.m <= c_sh[NORM_W-1 -: 32];
            r_z.e <= r_base + EXP_W'(r_bl) - EXP_W'(32);
        end
    end

    assign o_z = r_z;
endmodule

### rtl/ljf_mul.sv
// Two-stage mantissa multiplier: 32x32 product, then one-bit normalize.
// Depends on ljf_pkg.
module ljf_mul (
    input  logic           i_clk,
    input  logic           i_en,
    input  ljf_pkg::t_xnum i_a,
    input  ljf_pkg::t_xnum i_b,
    output ljf_pkg::t_xnum o_z
);
    import ljf_pkg::*;

    logic [63:0] r_p;
    t_exp        r_e;
    t_xnum       r_z;

    // Multiply; a zero mantissa gives a zero product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= 64'(i_a.m) * 64'(i_b.m);
            r_e <= i_a.e + i_b.e;
        end
    end

    // Keep the top 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_p[63]) begin
                r_z.m <= r_p[63:32];
                r_z.e <= r_e + EXP_W'(32);
            end else begin
                r_z.m <= r_p[62:31];
                r_z.e <= r_e + EXP_W'(31);
            end
        end
    end

    assign o_z = r_z;
endmodule

### rtl/ljf_recip.sv
// Pipelined reciprocal: floor(2^63 / m) by restoring division, three quotient
// bits per stage, then normalize. Depends on ljf_pkg.
module ljf_recip (
    input  logic           i_clk,
    input  logic           i_en,
    input  ljf_pkg::t_xnum i_x,
    output ljf_pkg::t_xnum o_z
);
    import ljf_pkg::*;

    localparam logic [31:0] REM_INIT = 32'h4000_0000;

    logic [31:0] r_rem [RCP_STAGES];
    logic [32:0] r_q   [RCP_STAGES];
    t_xnum       r_x   [RCP_STAGES];
    logic [31:0] c_rem_in [RCP_STAGES];
    logic [32:0] c_q_in   [RCP_STAGES];
    logic [31:0] c_m_in   [RCP_STAGES];
    logic [31:0] n_rem [RCP_STAGES];
    logic [32:0] n_q   [RCP_STAGES];
    t_xnum       r_z;

    // Stage inputs
    always_comb begin
        c_rem_in[0] = REM_INIT;
        c_q_in[0]   = '0;
        c_m_in[0]   = i_x.m;
        for (int j = 1; j < RCP_STAGES; j++) begin
            c_rem_in[j] = r_rem[j-1];
            c_q_in[j]   = r_q[j-1];
            c_m_in[j]   = r_x[j-1].m;
        end
    end

    // Shift, compare and subtract
    always_comb begin
        logic [32:0] sh;
        logic [31:0] rem;
        logic [32:0] q;
        logic        qb;
        sh  = '0;
        rem = '0;
        q   = '0;
        qb  = 1'b0;
        for (int j = 0; j < RCP_STAGES; j++) begin
            rem = c_rem_in[j];
            q   = c_q_in[j];
            for (int k = 0; k < RCP_STEPS; k++) begin
                sh = {rem, 1'b0};
                qb = (sh >= {1'b0, c_m_in[j]});
                if (qb) sh = sh - {1'b0, c_m_in[j]};
                rem = sh[31:0];
                q   = {q[31:0], qb};
            end
            n_rem[j] = rem;
            n_q[j]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            for (int j = 0; j < RCP_STAGES; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
            end
            for (int j = 1; j < RCP_STAGES; j++) r_x[j] <= r_x[j-1];
        end
    end

    // Normalize the 33-bit quotient; keep zero as zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_x[RCP_STAGES-1].m == '0) begin
                r_z.m <= '0;
                r_z.e <= '0;
            end else if (r_q[RCP_STAGES-1][32]) begin
                r_z.m <= r_q[RCP_STAGES-1][32:1];
                r_z.e <= -EXP_W'(63) - r_x[RCP_STAGES-1].e + EXP_W'(1);
            end else begin
                r_z.m <= r_q[RCP_STAGES-1][31:0];
                r_z.e <= -EXP_W'(63) - r_x[RCP_STAGES-1].e;
            end
        end
    end

    assign o_z = r_z;
endmodule

### rtl/ljf_fsub.sv
// Signed difference of two nonnegative numbers: order and align, subtract in a
// 63-bit window, then normalize. Depends on ljf_pkg and ljf_norm.
module ljf_fsub (
    input  logic           i_clk,
    input  logic           i_en,
    input  ljf_pkg::t_xnum i_a,
    input  ljf_pkg::t_xnum i_b,
    output ljf_pkg::t_xnum o_f,
    output logic           o_neg
);
    import ljf_pkg::*;

    logic              c_a_gt;
    logic [31:0]       r_big_m;
    t_exp              r_big_e;
    logic [31:0]       r_small_m;
    logic [EXP_W:0]    r_diff;
    logic              r_neg [3];
    logic [62:0]       c_y;
    logic [62:0]       r_dif;
    t_exp              r_e;

    // Pick the larger operand; a zero subtrahend leaves the minuend
    always_comb begin
        if (i_b.m == '0) c_a_gt = 1'b1;
        else if (i_a.m == '0) c_a_gt = 1'b0;
        else c_a_gt = (i_a.e > i_b.e) || ((i_a.e == i_b.e) && (i_a.m > i_b.m));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= !c_a_gt;
            if (c_a_gt) begin
                r_big_m   <= i_a.m;
                r_big_e   <= i_a.e;
                r_small_m <= i_b.m;
                r_diff    <= {i_a.e[EXP_W-1], i_a.e} - {i_b.e[EXP_W-1], i_b.e};
            end else begin
                r_big_m   <= i_b.m;
                r_big_e   <= i_b.e;
                r_small_m <= i_a.m;
                r_diff    <= {i_b.e[EXP_W-1], i_b.e} - {i_a.e[EXP_W-1], i_a.e};
            end
        end
    end

    // Align the smaller operand, truncating what falls off
    always_comb begin
        if (r_small_m == '0 || r_diff > (EXP_W+1)'(62)) c_y = '0;
        else c_y = {r_small_m, 31'b0} >> r_diff[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dif    <= {r_big_m, 31'b0} - c_y;
            r_e      <= r_big_e - EXP_W'(31);
            r_neg[1] <= r_neg[0];
            r_neg[2] <= r_neg[1];
        end
    end

    ljf_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_v    ({9'b0, r_dif}),
        .i_base (r_e),
        .o_z    (o_f)
    );

    // Hold the sign alongside the normalizer
    logic r_neg_out;
    always_ff @(posedge i_clk) begin
        if (i_en) r_neg_out <= r_neg[2];
    end
    assign o_neg = r_neg_out;
endmodule

### rtl/ljf_force.sv
// Force output: |d| times the force factor, scaled by its exponent, signed and
// saturated to Q24.24, over three stages. Depends on ljf_pkg.
module ljf_force (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [2:0][ljf_pkg::U_W-1:0]       i_u,
    input  logic [2:0]                         i_dneg,
    input  ljf_pkg::t_xnum                     i_f,
    input  logic                               i_fneg,
    output logic [2:0][ljf_pkg::FORCE_W-1:0]   o_force,
    output logic                               o_sat
);
    import ljf_pkg::*;

    logic [PROD_W-1:0]  r_p   [3];
    logic [2:0]         r_neg;
    t_exp               r_fe;
    logic [FORCE_W-1:0] r_mag [3];
    logic [2:0]         r_big;
    logic [2:0]         r_neg2;
    logic [FORCE_W-1:0] n_mag [3];
    logic [2:0]         n_big;
    logic [FORCE_W-1:0] n_force [3];
    logic [2:0]         n_sat;
    logic [2:0][FORCE_W-1:0] r_force;
    logic               r_sat;

    // Multiply magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i]   <= PROD_W'(i_u[i]) * PROD_W'(i_f.m);
                r_neg[i] <= i_dneg[i] ^ i_fneg;
            end
            r_fe <= i_f.e;
        end
    end

    // Scale by the exponent and flag overflow
    always_comb begin
        logic [PROD_W+FORCE_W-1:0] lw;
        logic [PROD_W-1:0]         rw;
        t_exp                      sh;
        lw = '0;
        rw = '0;
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = '0;
            n_big[i] = 1'b0;
            if (!r_fe[EXP_W-1]) begin
                if (r_fe > EXP_W'(48)) begin
                    n_big[i] = (r_p[i] != '0);
                end else begin
                    lw = (PROD_W+FORCE_W)'(r_p[i]) << r_fe[5:0];
                    n_big[i] = |lw[PROD_W+FORCE_W-1:FORCE_W];
                    n_mag[i] = lw[FORCE_W-1:0];
                end
            end else begin
                sh = -r_fe;
                if (sh >= EXP_W'(PROD_W)) rw = '0;
                else rw = r_p[i] >> sh[6:0];
                n_big[i] = |rw[PROD_W-1:FORCE_W];
                n_mag[i] = rw[FORCE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_mag[i] <= n_mag[i];
            r_big  <= n_big;
            r_neg2 <= r_neg;
        end
    end

    // Apply the sign and clip
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sat[i]   = 1'b0;
            n_force[i] = r_mag[i];
            if (!r_neg2[i]) begin
                if (r_big[i] || r_mag[i] > FORCE_MAX) begin
                    n_sat[i]   = 1'b1;
                    n_force[i] = FORCE_MAX;
                end
            end else begin
                if (r_big[i] || r_mag[i] > FORCE_MIN) begin
                    n_sat[i]   = 1'b1;
                    n_force[i] = FORCE_MIN;
                end else begin
                    n_force[i] = '0 - r_mag[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_force[i] <= n_force[i];
            r_sat <= |n_sat;
        end
    end

    assign o_force = r_force;
    assign o_sat   = r_sat;
endmodule

### rtl/lennard_jones_pair_force_top.sv
// Lennard-Jones 12-6 pair force pipeline, top level.
// Depends on ljf_pkg, ljf_norm, ljf_mul, ljf_recip, ljf_fsub, ljf_force.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) takes one atom pair per
//   beat: positions of atoms a and b, the image shift and both atom types.
//   Output channel (o_out_valid / i_out_stall / o_out) returns one beat per
//   pair: the Q24.24 force on atom a and a saturation flag.
//   The APB port holds the six 48-bit coefficients at byte address 8*i,
//   read back in place. Write them only while no pair is in flight.
//   Throughput is one pair per cycle while the output beat is not stalled;
//   the pipeline depth is set by the 11-stage reciprocal dividers and the
//   chain of four mantissa multipliers that forms r2^7.
//   When the output beat waits under i_out_stall, the whole pipeline holds
//   and o_in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits and the coefficients to zero.
module lennard_jones_pair_force_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ljf_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ljf_pkg::t_out o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import ljf_pkg::*;

    logic              en;
    logic [ST_OUT:1]   r_vld;
    logic [COEF_W-1:0] r_coef [NUM_COEF];
    logic [2:0]        cfg_idx;

    // Configuration registers
    assign cfg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) r_coef[i] <= '0;
        end else if (psel && penable && pwrite && cfg_idx < REG_COUNT) begin
            r_coef[cfg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    assign prdata = (cfg_idx < REG_COUNT) ? {16'b0, r_coef[cfg_idx]} : '0;

    // Global advance: hold everything while the output beat is stalled
    assign en          = !(r_vld[ST_OUT] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_OUT-1:1], i_in_valid};
        end
    end

    // Difference vector and pair code
    logic [2:0][D_W-1:0] c_d;
    logic [1:0]          c_pair;

    assign c_d[0] = {{2{i_in.pos_a_x[31]}}, i_in.pos_a_x}
                  - {{2{i_in.pos_b_x[31]}}, i_in.pos_b_x}
                  - {{2{i_in.image_shift_x[31]}}, i_in.image_shift_x};
    assign c_d[1] = {{2{i_in.pos_a_y[31]}}, i_in.pos_a_y}
                  - {{2{i_in.pos_b_y[31]}}, i_in.pos_b_y}
                  - {{2{i_in.image_shift_y[31]}}, i_in.image_shift_y};
    assign c_d[2] = {{2{i_in.pos_a_z[31]}}, i_in.pos_a_z}
                  - {{2{i_in.pos_b_z[31]}}, i_in.pos_b_z}
                  - {{2{i_in.image_shift_z[31]}}, i_in.image_shift_z};

    always_comb begin
        if (i_in.species_a && i_in.species_b) c_pair = PAIR_11;
        else if (i_in.species_a || i_in.species_b) c_pair = PAIR_01;
        else c_pair = PAIR_00;
    end

    logic [2:0][D_W-1:0]  r_d;
    logic [2:0][U_W-1:0]  c_u;
    logic [2:0][U_W-1:0]  r_u    [2:ST_FRC];
    logic [2:0]           r_dneg [1:ST_FRC];
    logic [1:0]           r_pair [1:ST_PAIR];
    logic [SQ_W-1:0]      r_sq   [3];
    logic [R_W-1:0]       r_r;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_u[i] = r_d[i][D_W-1] ? U_W'(~r_d[i] + 1'b1) : r_d[i][U_W-1:0];
        end
    end

    // Front stages and side delay lines
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d       <= c_d;
            r_dneg[1] <= {c_d[2][D_W-1], c_d[1][D_W-1], c_d[0][D_W-1]};
            r_pair[1] <= c_pair;
            r_u[2]    <= c_u;
            for (int i = 0; i < 3; i++) r_sq[i] <= SQ_W'(r_u[2][i]) * SQ_W'(r_u[2][i]);
            r_r <= R_W'(r_sq[0]) + R_W'(r_sq[1]) + R_W'(r_sq[2]);
            for (int k = 2; k <= ST_FRC; k++) r_dneg[k] <= r_dneg[k-1];
            for (int k = 3; k <= ST_FRC; k++) r_u[k] <= r_u[k-1];
            for (int k = 2; k <= ST_PAIR; k++) r_pair[k] <= r_pair[k-1];
        end
    end

    // r2 as a normalized number
    t_xnum s, s2, s3, s4, s7;
    t_xnum r_sd [7:10];
    t_xnum r_s3d [11:12];
    t_xnum r_s4d [13:14];

    ljf_norm u_norm_r2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    ({5'b0, r_r}),
        .i_base (-EXP_W'(48)),
        .o_z    (s)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[7] <= s;
            for (int k = 8; k <= 10; k++) r_sd[k] <= r_sd[k-1];
            r_s3d[11] <= s3;
            r_s3d[12] <= r_s3d[11];
            r_s4d[13] <= s4;
            r_s4d[14] <= r_s4d[13];
        end
    end

    // Powers of r2
    ljf_mul u_mul_s2 (.i_clk(i_clk), .i_en(en), .i_a(s),  .i_b(s),         .o_z(s2));
    ljf_mul u_mul_s3 (.i_clk(i_clk), .i_en(en), .i_a(s2), .i_b(r_sd[8]),   .o_z(s3));
    ljf_mul u_mul_s4 (.i_clk(i_clk), .i_en(en), .i_a(s3), .i_b(r_sd[10]),  .o_z(s4));
    ljf_mul u_mul_s7 (.i_clk(i_clk), .i_en(en), .i_a(s4), .i_b(r_s3d[12]), .o_z(s7));

    // Reciprocals of r2^7 and r2^4
    t_xnum rcp7, rcp4;

    ljf_recip u_rcp7 (.i_clk(i_clk), .i_en(en), .i_x(s7),         .o_z(rcp7));
    ljf_recip u_rcp4 (.i_clk(i_clk), .i_en(en), .i_x(r_s4d[14]),  .o_z(rcp4));

    // Coefficients of the type pair, normalized alongside the dividers
    logic [COEF_W-1:0] c_coef_a, c_coef_b;
    t_xnum             coef_a, coef_b;

    always_comb begin
        case (r_pair[ST_PAIR])
            PAIR_00: begin
                c_coef_a = r_coef[REG_REP_00];
                c_coef_b = r_coef[REG_ATT_00];
            end
            PAIR_01: begin
                c_coef_a = r_coef[REG_REP_01];
                c_coef_b = r_coef[REG_ATT_01];
            end
            PAIR_11: begin
                c_coef_a = r_coef[REG_REP_11];
                c_coef_b = r_coef[REG_ATT_11];
            end
            default: begin
                c_coef_a = '0;
                c_coef_b = '0;
            end
        endcase
    end

    ljf_norm u_norm_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    ({24'b0, c_coef_a}),
        .i_base (-EXP_W'(24)),
        .o_z    (coef_a)
    );

    ljf_norm u_norm_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_v    ({24'b0, c_coef_b}),
        .i_base (-EXP_W'(24)),
        .o_z    (coef_b)
    );

    // Repulsive and attractive terms, then their difference
    t_xnum term_a, term_b, f;
    logic  fneg;

    ljf_mul u_mul_ta (.i_clk(i_clk), .i_en(en), .i_a(coef_a), .i_b(rcp7), .o_z(term_a));
    ljf_mul u_mul_tb (.i_clk(i_clk), .i_en(en), .i_a(coef_b), .i_b(rcp4), .o_z(term_b));

    ljf_fsub u_fsub (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (term_a),
        .i_b   (term_b),
        .o_f   (f),
        .o_neg (fneg)
    );

    // Force components and output register
    logic [2:0][FORCE_W-1:0] force_v;
    logic                    force_sat;

    ljf_force u_force (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_u     (r_u[ST_FRC]),
        .i_dneg  (r_dneg[ST_FRC]),
        .i_f     (f),
        .i_fneg  (fneg),
        .o_force (force_v),
        .o_sat   (force_sat)
    );

    assign o_out.force_x   = force_v[0];
    assign o_out.force_y   = force_v[1];
    assign o_out.force_z   = force_v[2];
    assign o_out.saturated = force_sat;
endmodule

### rtl/ljf_checker.sv
// Port-level checks for the pair force top level, bound to it below.
// Depends on ljf_pkg and lennard_jones_pair_force_top.
module ljf_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_in_stall,
    input  logic          o_out_valid,
    input  logic          i_out_stall,
    input  ljf_pkg::t_out o_out
);
    import ljf_pkg::*;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Input holds only when a stalled output beat blocks the pipeline
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled output beat changed");

    // Saturation flag means some component sits at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.saturated) |->
        (o_out.force_x == FORCE_MAX || o_out.force_x == FORCE_MIN ||
         o_out.force_y == FORCE_MAX || o_out.force_y == FORCE_MIN ||
         o_out.force_z == FORCE_MAX || o_out.force_z == FORCE_MIN))
        else $error("saturation flag without a clipped component");
endmodule

bind lennard_jones_pair_force_top ljf_checker u_ljf_checker (.*);
